### rtl/focpi_pkg.sv
// shared types, constants and arithmetic helpers of the foc current loop
`timescale 1ns / 1ps
package focpi_pkg;

	localparam logic [2:0] REG_CURRENT_LIMIT   = 3'd0;
	localparam logic [2:0] REG_MAX_VOLTAGE_MOD = 3'd1;
	localparam logic [2:0] REG_PROP_GAIN       = 3'd2;
	localparam logic [2:0] REG_INTEG_GAIN      = 3'd3;
	localparam logic [2:0] REG_RAMP_RATE       = 3'd4;

	localparam logic [17:0] INV_SQRT3_Q16   = 18'd37837;
	localparam logic [18:0] CORDIC_GAIN_Q15 = 19'd19898;
	localparam logic [15:0] FILT_K_Q16      = 16'd6554;
	localparam logic [15:0] DECAY_Q16       = 16'd64881;
	localparam logic [20:0] RAMP_DIV        = 21'd2000000;
	localparam logic [19:0] INTEG_DIV       = 20'd1000000;

	typedef enum logic [1:0] {
		ALU_MUL,
		ALU_DIV,
		ALU_SQRT
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

	typedef enum logic [5:0] {
		S_IDLE, S_CORD, S_IBT, S_CIA, S_SIBT, S_CIBT, S_SIA, S_IDSQ, S_IQSQ, S_LIM,
		S_RMUL, S_RDIV, S_RD, S_RQ, S_FD, S_FQ, S_ERR, S_PD, S_PQ, S_VDSQ, S_VQSQ,
		S_MM, S_CHK, S_SQRT, S_SDM, S_SDD, S_SQM, S_SQD, S_DECD, S_DECQ, S_KD,
		S_IDM, S_IDV, S_IQM, S_IQV, S_DONE
	} state_t;

	// arctangent of 2^-i in units of 1/65536 turn
	function automatic logic [13:0] atan_turn(input logic [3:0] idx);
		logic [13:0] v;
		case (idx)
			4'd0:    v = 14'd8192;
			4'd1:    v = 14'd4836;
			4'd2:    v = 14'd2555;
			4'd3:    v = 14'd1297;
			4'd4:    v = 14'd651;
			4'd5:    v = 14'd326;
			4'd6:    v = 14'd163;
			4'd7:    v = 14'd81;
			4'd8:    v = 14'd41;
			4'd9:    v = 14'd20;
			4'd10:   v = 14'd10;
			4'd11:   v = 14'd5;
			4'd12:   v = 14'd3;
			4'd13:   v = 14'd1;
			default: v = 14'd0;
		endcase
		return v;
	endfunction

	function automatic logic [63:0] abs64(input logic signed [63:0] v);
		logic [63:0] r;
		r = v < 0 ? $unsigned(-v) : $unsigned(v);
		return r;
	endfunction

	// shift right by k, rounding to nearest with ties away from zero
	function automatic logic signed [63:0] rround(input logic signed [63:0] n, input int k);
		logic [63:0] m;
		logic [63:0] q;
		m = abs64(n);
		q = (m + (64'd1 << (k - 1))) >> k;
		return n < 0 ? -$signed(q) : $signed(q);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) r = 32'sh7fffffff;
		else if (v < -64'sd2147483648) r = 32'sh80000000;
		else r = 32'(v);
		return r;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
		logic signed [15:0] r;
		if (v > 64'sd32767) r = 16'sh7fff;
		else if (v < -64'sd32768) r = 16'sh8000;
		else r = 16'(v);
		return r;
	endfunction

endpackage

### rtl/focpi_cordic.sv
// rotation-mode cordic giving cos and sin of the rotor angle, one iteration per cycle
`timescale 1ns / 1ps
module focpi_cordic
	import focpi_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [15:0]        angle,
	output unit_sts_t          sts,
	output logic signed [18:0] cos_val,
	output logic signed [18:0] sin_val
);

	logic signed [18:0] x_q, y_q;
	logic signed [17:0] z_q;
	logic [3:0]         cnt_q;
	logic               flip_q, busy_q, done_q;
	logic               flip_n;
	logic [15:0]        fold;
	logic signed [18:0] dx, dy;
	logic signed [17:0] at;

	always_comb begin
		flip_n = (angle >= 16'd16384) && (angle < 16'd49152);
		fold = flip_n ? angle + 16'd32768 : angle;
		dx = y_q >>> cnt_q;
		dy = x_q >>> cnt_q;
		at = $signed({4'b0, atan_turn(cnt_q)});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			flip_q <= 1'b0;
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
			flip_q <= flip_n;
			x_q <= $signed(CORDIC_GAIN_Q15);
			y_q <= '0;
			z_q <= 18'($signed(fold));
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'd13) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign cos_val = flip_q ? -x_q : x_q;
	assign sin_val = flip_q ? -y_q : y_q;
	assign sts = '{busy: busy_q, done: done_q};

endmodule

### rtl/focpi_alu.sv
// shared bit-serial unit: shift-add multiply, restoring divide, digit-by-digit square root
`timescale 1ns / 1ps
module focpi_alu
	import focpi_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  alu_ctl_t    ctl,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output unit_sts_t   sts,
	output logic [63:0] res
);

	alu_op_t     op_q;
	logic [63:0] a_q, b_q, acc_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [33:0] div_sh;
	logic [35:0] sq_sh, sq_trial;

	always_comb begin
		div_sh = {acc_q[32:0], a_q[63]};
		sq_sh = {acc_q[33:0], a_q[63:62]};
		sq_trial = {2'b0, b_q[31:0], 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q <= ALU_MUL;
			cnt_q <= '0;
			a_q <= '0;
			b_q <= '0;
			acc_q <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			op_q <= ctl.op;
			cnt_q <= '0;
			a_q <= a;
			b_q <= (ctl.op == ALU_SQRT) ? 64'd0 : b;
			acc_q <= '0;
		end else if (busy_q) begin
			case (op_q)
				ALU_MUL: begin
					if (b_q == 64'd0) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						if (b_q[0]) acc_q <= acc_q + a_q;
						a_q <= a_q << 1;
						b_q <= b_q >> 1;
					end
				end
				ALU_DIV: begin
					if (div_sh >= {2'b0, b_q[31:0]}) begin
						acc_q <= 64'(div_sh - {2'b0, b_q[31:0]});
						a_q <= {a_q[62:0], 1'b1};
					end else begin
						acc_q <= 64'(div_sh);
						a_q <= {a_q[62:0], 1'b0};
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
				ALU_SQRT: begin
					if (sq_sh >= sq_trial) begin
						acc_q <= 64'(sq_sh - sq_trial);
						b_q <= {b_q[62:0], 1'b1};
					end else begin
						acc_q <= 64'(sq_sh);
						b_q <= {b_q[62:0], 1'b0};
					end
					a_q <= a_q << 2;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
				default: begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			endcase
		end else begin
			done_q <= 1'b0;
		end
	end

	always_comb begin
		case (op_q)
			ALU_MUL:  res = acc_q;
			ALU_DIV:  res = a_q;
			ALU_SQRT: res = {32'b0, b_q[31:0]};
			default:  res = acc_q;
		endcase
	end

	assign sts = '{busy: busy_q, done: done_q};

endmodule

### rtl/foc_current_pi_loop_core.sv
// top level: dq current pi loop sequencer around a shared bit-serial arithmetic unit
`timescale 1ns / 1ps
// One word in, one word out. With the loop off, a taken word goes straight to the done
// step, which moves its result into the output register. With the loop running, a word
// first runs the cordic and then a microcoded sequence of steps on one bit-serial
// arithmetic unit. A multiply step runs until the significant bits of its second operand
// are used up. Three divides run on every word with the loop running: the ramp step, then
// two on either the saturated or the integrating path. The square root runs only on the
// saturated path. A new word is taken once the previous one has reached the output
// register, which holds its result until taken. A stalled output holds the sequence in its
// last step.
module foc_current_pi_loop_core
	import focpi_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [25:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] phase_b_current,
	input  logic signed [15:0] phase_c_current,
	input  logic [15:0]        rotor_angle,
	input  logic [15:0]        time_step,
	input  logic signed [15:0] target_d,
	input  logic signed [15:0] target_q,
	input  logic               enable,
	input  logic               clear_error,
	input  logic               apply_fault,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] volt_d,
	output logic signed [15:0] volt_q,
	output logic signed [15:0] filtered_d,
	output logic signed [15:0] filtered_q,
	output logic [1:0]         error_flags,
	output logic               valid_res
);

	state_t state_q, state_n;

	logic [14:0] lim_q;
	logic [15:0] mvm_q;
	logic [16:0] pgain_q;
	logic [25:0] igain_q;
	logic [15:0] rrate_q;

	logic signed [47:0] ramped_d_q, ramped_q_q;
	logic signed [31:0] filt_d_q, filt_q_q, integ_d_q, integ_q_q;
	logic               running_q, last_en_q, valid_run_q;
	logic [1:0]         err_q;

	logic [15:0]        ang_q, dt_q;
	logic signed [15:0] td_q, tq_q;
	logic signed [17:0] ia_q, ibt_q;
	logic signed [16:0] dbc_q;
	logic signed [19:0] id_q, iq_q;
	logic signed [63:0] p_q;
	logic [35:0]        step_q;
	logic signed [21:0] ed_q, eq_q;
	logic signed [31:0] vd_q, vq_q;
	logic [31:0]        mag_q;
	logic [41:0]        kd_q;
	logic               sat_q;

	logic               out_valid_q;

	logic        accept, run_n, clr_n;
	logic [1:0]  err_n;

	alu_ctl_t    alu_ctl;
	unit_sts_t   alu_sts, cor_sts;
	logic        alu_req, cor_req, mul_neg;
	alu_op_t     alu_op;
	logic [63:0] alu_a, alu_b, alu_res;
	logic signed [63:0] prod, sres;
	logic signed [18:0] cos_v, sin_v;
	logic signed [63:0] diff;

	function automatic logic signed [47:0] ramp_axis(input logic signed [47:0] r,
			input logic signed [15:0] tgt, input logic [14:0] lim, input logic [35:0] step);
		logic signed [16:0] tc;
		logic signed [48:0] t, lo, hi;
		logic signed [48:0] res;
		if (17'(tgt) > $signed({2'b0, lim})) tc = $signed({2'b0, lim});
		else if (17'(tgt) < -$signed({2'b0, lim})) tc = -$signed({2'b0, lim});
		else tc = 17'(tgt);
		t = 49'(tc) <<< 24;
		lo = 49'(r) - $signed({13'b0, step});
		hi = 49'(r) + $signed({13'b0, step});
		if (t < lo) res = lo;
		else if (t > hi) res = hi;
		else res = t;
		return 48'(res);
	endfunction

	focpi_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cor_req && !cor_sts.busy && !cor_sts.done),
		.angle   (ang_q),
		.sts     (cor_sts),
		.cos_val (cos_v),
		.sin_val (sin_v)
	);

	assign alu_ctl = '{start: alu_req && !alu_sts.busy && !alu_sts.done, op: alu_op};

	focpi_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (alu_ctl),
		.a      (alu_a),
		.b      (alu_b),
		.sts    (alu_sts),
		.res    (alu_res)
	);

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign sres = $signed(alu_res);
	assign prod = mul_neg ? -sres : sres;

	// enable, fault and error-clear handling for the incoming word
	always_comb begin
		err_n = clear_error ? 2'b00 : err_q;
		run_n = running_q;
		clr_n = 1'b0;
		if (apply_fault && running_q) begin
			err_n[1] = 1'b1;
			run_n = 1'b0;
			clr_n = 1'b1;
		end
		if (enable && !last_en_q) begin
			run_n = 1'b1;
			err_n = 2'b00;
		end
		if (!enable) begin
			run_n = 1'b0;
			clr_n = 1'b1;
		end
	end

	always_comb begin
		state_n = state_q;
		alu_req = 1'b0;
		alu_op = ALU_MUL;
		alu_a = '0;
		alu_b = '0;
		mul_neg = 1'b0;
		cor_req = 1'b0;
		diff = '0;
		case (state_q)
			S_IDLE: if (accept) state_n = run_n ? S_CORD : S_DONE;
			S_CORD: begin
				cor_req = 1'b1;
				if (cor_sts.done) state_n = S_IBT;
			end
			S_IBT: begin
				alu_req = 1'b1;
				alu_a = abs64(64'(dbc_q));
				alu_b = 64'(INV_SQRT3_Q16);
				mul_neg = dbc_q < 0;
				if (alu_sts.done) state_n = S_CIA;
			end
			S_CIA: begin
				alu_req = 1'b1;
				alu_a = abs64(64'(cos_v));
				alu_b = abs64(64'(ia_q));
				mul_neg = (cos_v < 0) ^ (ia_q < 0);
				if (alu_sts.done) state_n = S_SIBT;
			end
			S_SIBT: begin
				alu_req = 1'b1;
				alu_a = abs64(64'(sin_v));
				alu_b = abs64(64'(ibt_q));
				mul_neg = (sin_v < 0) ^ (ibt_q < 0);
				if (alu_sts.done) state_n = S_CIBT;
			end
			S_CIBT: begin
				alu_req = 1'b1;
				alu_a = abs64(64'(cos_v));
				alu_b = abs64(64'(ibt_q));
				mul_neg = (cos_v < 0) ^ (ibt_q < 0);
				if (alu_sts.done) state_n = S_SIA;
			end
			S_SIA: begin
				alu_req = 1'b1;
				alu_a = abs64(64'(sin_v));
				alu_b = abs64(64'(ia_q));
				mul_neg = (sin_v < 0) ^ (ia_q < 0);
				if (alu_sts.done) state_n = S_IDSQ;
			end
			S_IDSQ: begin
				alu_req = 1'b1;
				alu_a = abs64(64'(id_q));
				alu_b = abs64(64'(id_q));
				if (alu_sts.done) state_n = S_IQSQ;
			end
			S_IQSQ: begin
				alu_req = 1'b1;
				alu_a = abs64(64'(iq_q));
				alu_b = abs64(64'(iq_q));
				if (alu_sts.done) state_n = S_LIM;
			end
			S_LIM: begin
				alu_req = 1'b1;
				alu_a = 64'(lim_q);
				alu_b = 64'(lim_q);
				if (alu_sts.done) state_n = S_RMUL;
			end
			S_RMUL: begin
				alu_req = 1'b1;
				alu_a = 64'(rrate_q);
				alu_b = 64'(dt_q);
				if (alu_sts.done) state_n = S_RDIV;
			end
			S_RDIV: begin
				alu_req = 1'b1;
				alu_op = ALU_DIV;
				alu_a = ($unsigned(p_q) << 24) + 64'(INTEG_DIV);
				alu_b = 64'(RAMP_DIV);
				if (alu_sts.done) state_n = S_RD;
			end
			S_RD: state_n = S_RQ;
			S_RQ: state_n = S_FD;
			S_FD: begin
				diff = (64'(id_q) <<< 12) - 64'(filt_d_q);
				alu_req = 1'b1;
				alu_a = abs64(diff);
				alu_b = 64'(FILT_K_Q16);
				mul_neg = diff < 0;
				if (alu_sts.done) state_n = S_FQ;
			end
			S_FQ: begin
				diff = (64'(iq_q) <<< 12) - 64'(filt_q_q);
				alu_req = 1'b1;
				alu_a = abs64(diff);
				alu_b = 64'(FILT_K_Q16);
				mul_neg = diff < 0;
				if (alu_sts.done) state_n = S_ERR;
			end
			S_ERR: state_n = S_PD;
			S_PD: begin
				alu_req = 1'b1;
				alu_a = abs64(64'(ed_q));
				alu_b = 64'(pgain_q);
				mul_neg = ed_q < 0;
				if (alu_sts.done) state_n = S_PQ;
			end
			S_PQ: begin
				alu_req = 1'b1;
				alu_a = abs64(64'(eq_q));
				alu_b = 64'(pgain_q);
				mul_neg = eq_q < 0;
				if (alu_sts.done) state_n = S_VDSQ;
			end
			S_VDSQ: begin
				alu_req = 1'b1;
				alu_a = abs64(64'(vd_q));
				alu_b = abs64(64'(vd_q));
				if (alu_sts.done) state_n = S_VQSQ;
			end
			S_VQSQ: begin
				alu_req = 1'b1;
				alu_a = abs64(64'(vq_q));
				alu_b = abs64(64'(vq_q));
				if (alu_sts.done) state_n = S_MM;
			end
			S_MM: begin
				alu_req = 1'b1;
				alu_a = 64'(mvm_q);
				alu_b = 64'(mvm_q);
				if (alu_sts.done) state_n = S_CHK;
			end
			S_CHK: state_n = sat_q ? S_SQRT : S_KD;
			S_SQRT: begin
				alu_req = 1'b1;
				alu_op = ALU_SQRT;
				alu_a = $unsigned(p_q) << 2;
				if (alu_sts.done) state_n = S_SDM;
			end
			S_SDM: begin
				alu_req = 1'b1;
				alu_a = abs64(64'(vd_q));
				alu_b = 64'(mvm_q);
				mul_neg = vd_q < 0;
				if (alu_sts.done) state_n = S_SDD;
			end
			S_SDD: begin
				alu_req = 1'b1;
				alu_op = ALU_DIV;
				alu_a = abs64(p_q) + 64'(mag_q >> 1);
				alu_b = 64'(mag_q);
				if (alu_sts.done) state_n = S_SQM;
			end
			S_SQM: begin
				alu_req = 1'b1;
				alu_a = abs64(64'(vq_q));
				alu_b = 64'(mvm_q);
				mul_neg = vq_q < 0;
				if (alu_sts.done) state_n = S_SQD;
			end
			S_SQD: begin
				alu_req = 1'b1;
				alu_op = ALU_DIV;
				alu_a = abs64(p_q) + 64'(mag_q >> 1);
				alu_b = 64'(mag_q);
				if (alu_sts.done) state_n = S_DECD;
			end
			S_DECD: begin
				alu_req = 1'b1;
				alu_a = abs64(64'(integ_d_q));
				alu_b = 64'(DECAY_Q16);
				mul_neg = integ_d_q < 0;
				if (alu_sts.done) state_n = S_DECQ;
			end
			S_DECQ: begin
				alu_req = 1'b1;
				alu_a = abs64(64'(integ_q_q));
				alu_b = 64'(DECAY_Q16);
				mul_neg = integ_q_q < 0;
				if (alu_sts.done) state_n = S_DONE;
			end
			S_KD: begin
				alu_req = 1'b1;
				alu_a = 64'(igain_q);
				alu_b = 64'(dt_q);
				if (alu_sts.done) state_n = S_IDM;
			end
			S_IDM: begin
				alu_req = 1'b1;
				alu_a = abs64(64'(ed_q));
				alu_b = 64'(kd_q);
				mul_neg = ed_q < 0;
				if (alu_sts.done) state_n = S_IDV;
			end
			S_IDV: begin
				alu_req = 1'b1;
				alu_op = ALU_DIV;
				alu_a = abs64(p_q) + 64'(INTEG_DIV >> 1);
				alu_b = 64'(INTEG_DIV);
				if (alu_sts.done) state_n = S_IQM;
			end
			S_IQM: begin
				alu_req = 1'b1;
				alu_a = abs64(64'(eq_q));
				alu_b = 64'(kd_q);
				mul_neg = eq_q < 0;
				if (alu_sts.done) state_n = S_IQV;
			end
			S_IQV: begin
				alu_req = 1'b1;
				alu_op = ALU_DIV;
				alu_a = abs64(p_q) + 64'(INTEG_DIV >> 1);
				alu_b = 64'(INTEG_DIV);
				if (alu_sts.done) state_n = S_DONE;
			end
			S_DONE: if (!out_valid_q || out_ready) state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= 15'd640;
			mvm_q <= 16'd5243;
			pgain_q <= 17'd131;
			igain_q <= 26'd65536;
			rrate_q <= 16'd26;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_CURRENT_LIMIT:   lim_q <= cfg_data[14:0];
				REG_MAX_VOLTAGE_MOD: mvm_q <= cfg_data[15:0];
				REG_PROP_GAIN:       pgain_q <= cfg_data[16:0];
				REG_INTEG_GAIN:      igain_q <= cfg_data[25:0];
				REG_RAMP_RATE:       rrate_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramped_d_q <= '0;
			ramped_q_q <= '0;
			filt_d_q <= '0;
			filt_q_q <= '0;
			integ_d_q <= '0;
			integ_q_q <= '0;
			running_q <= 1'b0;
			last_en_q <= 1'b0;
			err_q <= 2'b00;
			valid_run_q <= 1'b0;
		end else begin
			if (accept) begin
				running_q <= run_n;
				last_en_q <= enable;
				err_q <= err_n;
				valid_run_q <= run_n;
				if (clr_n) begin
					ramped_d_q <= '0;
					ramped_q_q <= '0;
					filt_d_q <= '0;
					filt_q_q <= '0;
					integ_d_q <= '0;
					integ_q_q <= '0;
				end
			end
			case (state_q)
				S_LIM: if (alu_sts.done) err_q[0] <= $unsigned(p_q) > alu_res;
				S_RD:  ramped_d_q <= ramp_axis(ramped_d_q, td_q, lim_q, step_q);
				S_RQ:  ramped_q_q <= ramp_axis(ramped_q_q, tq_q, lim_q, step_q);
				S_FD:  if (alu_sts.done) filt_d_q <= sat32(64'(filt_d_q) + rround(prod, 16));
				S_FQ:  if (alu_sts.done) filt_q_q <= sat32(64'(filt_q_q) + rround(prod, 16));
				S_DECD: if (alu_sts.done) integ_d_q <= 32'(rround(prod, 16));
				S_DECQ: if (alu_sts.done) integ_q_q <= 32'(rround(prod, 16));
				S_IDV: if (alu_sts.done)
					integ_d_q <= sat32(64'(integ_d_q) + (p_q < 0 ? -sres : sres));
				S_IQV: if (alu_sts.done)
					integ_q_q <= sat32(64'(integ_q_q) + (p_q < 0 ? -sres : sres));
				default: ;
			endcase
		end
	end

	// per-word working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			ang_q <= rotor_angle;
			dt_q <= time_step;
			td_q <= target_d;
			tq_q <= target_q;
			ia_q <= -(18'(phase_b_current) + 18'(phase_c_current));
			dbc_q <= 17'(phase_b_current) - 17'(phase_c_current);
			vd_q <= '0;
			vq_q <= '0;
		end
		if (alu_sts.done) begin
			case (state_q)
				S_IBT:  ibt_q <= 18'(rround(prod, 16));
				S_CIA:  p_q <= prod;
				S_SIBT: id_q <= 20'(rround(p_q + prod, 15));
				S_CIBT: p_q <= prod;
				S_SIA:  iq_q <= 20'(rround(p_q - prod, 15));
				S_IDSQ: p_q <= prod;
				S_IQSQ: p_q <= p_q + prod;
				S_RMUL: p_q <= prod;
				S_RDIV: step_q <= alu_res[35:0];
				S_PD:   vd_q <= 32'(rround(64'(integ_d_q), 8) + rround(prod, 8));
				S_PQ:   vq_q <= 32'(rround(64'(integ_q_q), 8) + rround(prod, 8));
				S_VDSQ: p_q <= prod;
				S_VQSQ: p_q <= p_q + prod;
				S_MM:   sat_q <= ($unsigned(p_q) << 2) > alu_res;
				S_SQRT: mag_q <= (alu_res == 64'd0) ? 32'd1 : alu_res[31:0];
				S_SDM:  p_q <= prod;
				S_SDD:  vd_q <= 32'(p_q < 0 ? -sres : sres);
				S_SQM:  p_q <= prod;
				S_SQD:  vq_q <= 32'(p_q < 0 ? -sres : sres);
				S_KD:   kd_q <= alu_res[41:0];
				S_IDM:  p_q <= prod;
				S_IQM:  p_q <= prod;
				default: ;
			endcase
		end
		if (state_q == S_ERR) begin
			ed_q <= 22'(rround(64'(ramped_d_q), 24) - 64'(id_q));
			eq_q <= 22'(rround(64'(ramped_q_q), 24) - 64'(iq_q));
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			volt_d <= sat16(64'(vd_q));
			volt_q <= sat16(64'(vq_q));
			filtered_d <= sat16(rround(64'(filt_d_q), 12));
			filtered_q <= sat16(rround(64'(filt_q_q), 12));
			error_flags <= err_q;
			valid_res <= valid_run_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### verif/foc_current_pi_loop_checker.sv
// checker for the foc current loop: watches both channels, predicts each result and compares
`timescale 1ns / 1ps
module foc_current_pi_loop_checker
	import focpi_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [25:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [15:0] phase_b_current,
	input  logic signed [15:0] phase_c_current,
	input  logic [15:0]        rotor_angle,
	input  logic [15:0]        time_step,
	input  logic signed [15:0] target_d,
	input  logic signed [15:0] target_q,
	input  logic               enable,
	input  logic               clear_error,
	input  logic               apply_fault,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [15:0] volt_d,
	input  logic signed [15:0] volt_q,
	input  logic signed [15:0] filtered_d,
	input  logic signed [15:0] filtered_q,
	input  logic [1:0]         error_flags,
	input  logic               valid_res,
	output int                 fail_count,
	output int                 pending
);

	typedef struct {
		logic signed [15:0] vd;
		logic signed [15:0] vq;
		logic signed [15:0] fd;
		logic signed [15:0] fq;
		logic [1:0]         flags;
		logic               ran;
	} loop_word_t;

	localparam int ATAN_TBL [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20,
		10, 5, 3, 1};

	loop_word_t expected_words [$];

	logic [14:0] lim_reg;
	logic [15:0] vmax_reg;
	logic [16:0] kp_reg;
	logic [25:0] ki_reg;
	logic [15:0] ramp_reg;
	longint ramp_d, ramp_q;
	int     lpf_d, lpf_q, acc_d, acc_q;
	bit     loop_on, prev_en;
	logic [1:0] err_reg;
	int     printed;

	function automatic longint rdiv(longint n, longint d);
		longint m, q;
		m = n < 0 ? -n : n;
		q = (m + d / 2) / d;
		return n < 0 ? -q : q;
	endfunction

	function automatic longint clip(longint v, longint lim);
		return v > lim ? lim : (v < -lim - 1 ? -lim - 1 : v);
	endfunction

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint slew(longint r, longint tgt, longint lim, longint stp);
		longint t;
		t = (tgt > lim ? lim : (tgt < -lim ? -lim : tgt)) * 64'sd16777216;
		if (t < r - stp) return r - stp;
		if (t > r + stp) return r + stp;
		return t;
	endfunction

	function automatic int lowpass(int f, longint meas);
		longint diff;
		diff = meas * 4096 - longint'(f);
		return int'(clip(longint'(f) + rdiv(diff * 6554, 65536), 64'sd2147483647));
	endfunction

	task automatic clear_loop_state();
		ramp_d = 0; ramp_q = 0;
		lpf_d = 0; lpf_q = 0; acc_d = 0; acc_q = 0;
	endtask

	task automatic predict_word(output loop_word_t w);
		longint ib, ic, ia, ibt, id, iq, stp, ed, eq, vd, vq, sum, lim, mag, kd;
		int x, y, z, dx, dy, cs, sn;
		int unsigned a;
		bit flip;
		ib = phase_b_current;
		ic = phase_c_current;
		vd = 0;
		vq = 0;
		w.ran = 1'b0;
		if (clear_error) err_reg = 2'b00;
		if (apply_fault && loop_on) begin
			err_reg[1] = 1'b1;
			loop_on = 0;
			clear_loop_state();
		end
		if (enable && !prev_en) begin
			loop_on = 1;
			err_reg = 2'b00;
		end
		if (!enable) begin
			loop_on = 0;
			clear_loop_state();
		end
		prev_en = enable;
		if (loop_on) begin
			lim = lim_reg;
			ia = -ib - ic;
			ibt = rdiv((ib - ic) * 37837, 65536);
			flip = rotor_angle >= 16384 && rotor_angle < 49152;
			a = flip ? ((rotor_angle + 32768) & 16'hffff) : rotor_angle;
			z = a >= 32768 ? int'(a) - 65536 : int'(a);
			x = 19898;
			y = 0;
			for (int i = 0; i < 14; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= ATAN_TBL[i];
				end else begin
					x += dx; y -= dy; z += ATAN_TBL[i];
				end
			end
			cs = flip ? -x : x;
			sn = flip ? -y : y;
			id = rdiv(longint'(cs) * ia + longint'(sn) * ibt, 32768);
			iq = rdiv(longint'(cs) * ibt - longint'(sn) * ia, 32768);
			if (id * id + iq * iq > lim * lim) err_reg[0] = 1'b1;
			else err_reg[0] = 1'b0;
			stp = (longint'(ramp_reg) * longint'(time_step) * 64'sd16777216 + 1000000)
				/ 2000000;
			ramp_d = slew(ramp_d, target_d, lim, stp);
			ramp_q = slew(ramp_q, target_q, lim, stp);
			lpf_d = lowpass(lpf_d, id);
			lpf_q = lowpass(lpf_q, iq);
			ed = rdiv(ramp_d, 64'sd16777216) - id;
			eq = rdiv(ramp_q, 64'sd16777216) - iq;
			vd = rdiv(acc_d, 256) + rdiv(ed * kp_reg, 256);
			vq = rdiv(acc_q, 256) + rdiv(eq * kp_reg, 256);
			sum = vd * vd + vq * vq;
			if (sum * 4 > longint'(vmax_reg) * longint'(vmax_reg)) begin
				mag = longint'(root_floor(longint'(sum * 4)));
				if (mag == 0) mag = 1;
				vd = rdiv(vd * vmax_reg, mag);
				vq = rdiv(vq * vmax_reg, mag);
				acc_d = int'(rdiv(longint'(acc_d) * 64881, 65536));
				acc_q = int'(rdiv(longint'(acc_q) * 64881, 65536));
			end else begin
				kd = longint'(ki_reg) * longint'(time_step);
				acc_d = int'(clip(longint'(acc_d) + rdiv(ed * kd, 1000000), 64'sd2147483647));
				acc_q = int'(clip(longint'(acc_q) + rdiv(eq * kd, 1000000), 64'sd2147483647));
			end
			vd = clip(vd, 32767);
			vq = clip(vq, 32767);
			w.ran = 1'b1;
		end
		w.vd = 16'(vd);
		w.vq = 16'(vq);
		w.fd = 16'(clip(rdiv(lpf_d, 4096), 32767));
		w.fq = 16'(clip(rdiv(lpf_q, 4096), 32767));
		w.flags = err_reg;
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		if (printed < 40) $display("mismatch %s: got %0d expected %0d at %0t", what, got,
			want, $realtime);
		printed++;
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		loop_word_t w;
		if (!arst_n) begin
			lim_reg = 15'd640; vmax_reg = 16'd5243; kp_reg = 17'd131;
			ki_reg = 26'd65536; ramp_reg = 16'd26;
			clear_loop_state();
			loop_on = 0; prev_en = 0; err_reg = 2'b00;
			expected_words.delete();
			pending = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_CURRENT_LIMIT:   lim_reg = cfg_data[14:0];
					REG_MAX_VOLTAGE_MOD: vmax_reg = cfg_data[15:0];
					REG_PROP_GAIN:       kp_reg = cfg_data[16:0];
					REG_INTEG_GAIN:      ki_reg = cfg_data[25:0];
					REG_RAMP_RATE:       ramp_reg = cfg_data[15:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					report_mismatch("word with none expected", 1, 0);
				end else begin
					w = expected_words.pop_front();
					if (volt_d !== w.vd) report_mismatch("volt_d", volt_d, w.vd);
					if (volt_q !== w.vq) report_mismatch("volt_q", volt_q, w.vq);
					if (filtered_d !== w.fd) report_mismatch("filtered_d", filtered_d, w.fd);
					if (filtered_q !== w.fq) report_mismatch("filtered_q", filtered_q, w.fq);
					if (error_flags !== w.flags)
						report_mismatch("error_flags", error_flags, w.flags);
					if (valid_res !== w.ran) report_mismatch("valid_res", valid_res, w.ran);
				end
			end
			if (in_valid && in_ready) begin
				predict_word(w);
				expected_words.push_back(w);
			end
			pending = expected_words.size();
		end
	end

endmodule

### verif/tb.sv
// testbench top for the foc current loop: stimulus, configuration phases and verdict
`timescale 1ns / 1ps
module tb;
	import focpi_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [2:0]         cfg_index;
	logic [25:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic signed [15:0] phase_b_current;
	logic signed [15:0] phase_c_current;
	logic [15:0]        rotor_angle;
	logic [15:0]        time_step;
	logic signed [15:0] target_d;
	logic signed [15:0] target_q;
	logic               enable;
	logic               clear_error;
	logic               apply_fault;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] volt_d;
	logic signed [15:0] volt_q;
	logic signed [15:0] filtered_d;
	logic signed [15:0] filtered_q;
	logic [1:0]         error_flags;
	logic               valid_res;
	int                 fail_count;
	int                 pending;
	bit                 no_gaps;

	foc_current_pi_loop_core dut (.*);
	foc_current_pi_loop_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#40000000;
		$display("[foc_current_pi_loop_core] ERROR");
		$finish;
	end

	// receiver stalls at random unless a gap-free stretch is running
	always @(posedge clk) begin
		out_ready <= no_gaps ? 1'b1 : ($urandom_range(99) >= 26);
	end

	task automatic send_word(input logic [15:0] b, input logic [15:0] c,
		input logic [15:0] ang, input logic [15:0] dt, input logic [15:0] td,
		input logic [15:0] tq, input logic en, input logic clr, input logic flt);
		while (!no_gaps && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		phase_b_current <= b; phase_c_current <= c; rotor_angle <= ang;
		time_step <= dt; target_d <= td; target_q <= tq;
		enable <= en; clear_error <= clr; apply_fault <= flt;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_regs(input logic [25:0] lim, input logic [25:0] vmax,
		input logic [25:0] kp, input logic [25:0] ki, input logic [25:0] rr);
		logic [25:0] vals [5];
		vals = '{lim, vmax, kp, ki, rr};
		for (int i = 0; i < 5; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// mostly a held enable with moderate currents, now and then faults and full-range noise
	task automatic random_word(input int lim);
		logic [15:0] b, c, td, tq;
		logic en, clr, flt;
		int span;
		span = lim < 64 ? 64 : lim;
		if ($urandom_range(9) < 7) begin
			b = 16'($signed($urandom_range(2 * span)) - span);
			c = 16'($signed($urandom_range(2 * span)) - span);
		end else begin
			b = 16'($urandom);
			c = 16'($urandom);
		end
		if ($urandom_range(9) < 7) begin
			td = 16'($signed($urandom_range(2 * span + 200)) - span - 100);
			tq = 16'($signed($urandom_range(2 * span + 200)) - span - 100);
		end else begin
			td = 16'($urandom);
			tq = 16'($urandom);
		end
		en = $urandom_range(99) >= 6;
		clr = $urandom_range(99) < 5;
		flt = $urandom_range(99) < 3;
		send_word(b, c, 16'($urandom), $urandom_range(3) == 0 ? 16'($urandom) :
			16'($urandom_range(200)), td, tq, en, clr, flt);
	endtask

	initial begin
		int lim;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0;
		phase_b_current = '0; phase_c_current = '0; rotor_angle = '0; time_step = '0;
		target_d = '0; target_q = '0; enable = 1'b0; clear_error = 1'b0;
		apply_fault = 1'b0;
		no_gaps = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at reset settings
		send_word(16'd0, 16'd0, 16'd0, 16'd50, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0);
		send_word(16'd0, 16'd0, 16'd0, 16'd50, 16'd100, -16'sd100, 1'b1, 1'b0, 1'b0);
		send_word(16'sh7fff, 16'sh8000, 16'd16384, 16'd65535, 16'sh7fff, 16'sh8000,
			1'b1, 1'b0, 1'b0);
		send_word(16'sh8000, 16'sh8000, 16'd32768, 16'd0, 16'sh8000, 16'sh7fff,
			1'b1, 1'b0, 1'b0);
		send_word(16'sh7fff, 16'sh7fff, 16'd49152, 16'd100, 16'd0, 16'd0, 1'b1, 1'b0, 1'b0);
		send_word(16'd50, -16'sd20, 16'd65535, 16'd100, 16'd0, 16'd0, 1'b1, 1'b1, 1'b0);
		send_word(16'd50, -16'sd20, 16'd16383, 16'd100, 16'd0, 16'd0, 1'b1, 1'b0, 1'b1);
		// held enable after a fault keeps the loop off
		send_word(16'd50, -16'sd20, 16'd49151, 16'd100, 16'd0, 16'd0, 1'b1, 1'b0, 1'b0);
		send_word(16'd0, 16'd0, 16'd0, 16'd100, 16'd0, 16'd0, 1'b1, 1'b0, 1'b1);
		send_word(16'd0, 16'd0, 16'd0, 16'd100, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0);
		send_word(16'd10, 16'd10, 16'd1000, 16'd100, 16'd640, 16'd640, 1'b1, 1'b0, 1'b0);
		send_word(16'd2000, -16'sd2000, 16'd1000, 16'd100, 16'd0, 16'd0, 1'b1, 1'b0, 1'b0);
		send_word(16'd1, 16'd1, 16'd1000, 16'd100, 16'd0, 16'd0, 1'b1, 1'b1, 1'b0);
		send_word(16'd1, 16'd1, 16'd1000, 16'd100, 16'd0, 16'd0, 1'b0, 1'b1, 1'b1);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: lim = 640;
				1: begin
					write_regs(26'd25600, 26'd62259, 26'd65536, 26'd65536000, 26'd65535);
					lim = 25600;
				end
				2: begin
					write_regs(26'd0, 26'd0, 26'd0, 26'd0, 26'd0);
					lim = 0;
				end
				default: begin
					lim = $urandom_range(25600);
					write_regs(26'(lim), 26'($urandom_range(62259)),
						26'($urandom_range(65536)), 26'($urandom_range(65536000)),
						26'($urandom_range(65535)));
				end
			endcase
			for (int n = 0; n < 330; n++) begin
				no_gaps = (n >= 100 && n < 160);
				random_word(lim);
			end
			no_gaps = 1'b0;
			drain();
		end

		if (fail_count == 0) begin
			$display("[foc_current_pi_loop_core] OK");
		end else begin
			$display("[foc_current_pi_loop_core] ERROR");
		end
		$finish;
	end

endmodule

### foc_current_pi_loop_core.f
rtl/focpi_pkg.sv
rtl/focpi_cordic.sv
rtl/focpi_alu.sv
rtl/foc_current_pi_loop_core.sv
verif/foc_current_pi_loop_checker.sv
verif/tb.sv
